// ----- rtl/fce_pkg.sv -----
// ----------------------------------------------------------------------------
// fce_pkg
// Shared types and constants for the front coding encoder: length widths,
// result kinds, the word job passed from front to back, and the result item.
// ----------------------------------------------------------------------------
package fce_pkg;

  // byte and length widths (lengths are carried in 6-bit result fields)
  localparam int BYTE_W           = 8;
  localparam int LEN_W            = 6;
  localparam int MAX_WORD_LEN_DEF = 32;

  // word job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // result item kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // one finished word, ready to be emitted
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] pre;
    logic [LEN_W-1:0] suf;
    logic [LEN_W-1:0] len;
    logic             trunc;
  } job_t;

  // back reports a word fully emitted, freeing its bank
  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

  // one result item
  typedef struct packed {
    logic              kind;
    logic [LEN_W-1:0]  pre;
    logic [LEN_W-1:0]  suf;
    logic [BYTE_W-1:0] data;
    logic              trunc;
    logic              last;
  } result_t;

endpackage

// ----- rtl/fce_store.sv -----
// ----------------------------------------------------------------------------
// fce_store
// Two-bank word memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fce_store #(
  parameter int  MAX_WORD_LEN = fce_pkg::MAX_WORD_LEN_DEF,
  localparam int IDX_W        = $clog2(MAX_WORD_LEN)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic                      wr_bank,
  input  logic [IDX_W-1:0]          wr_idx,
  input  logic [fce_pkg::BYTE_W-1:0] wr_data,
  input  logic                      a_en,
  input  logic                      a_bank,
  input  logic [IDX_W-1:0]          a_idx,
  output logic [fce_pkg::BYTE_W-1:0] a_data,
  input  logic                      b_en,
  input  logic                      b_bank,
  input  logic [IDX_W-1:0]          b_idx,
  output logic [fce_pkg::BYTE_W-1:0] b_data
);
  import fce_pkg::*;

  logic [BYTE_W-1:0] mem_r [2][MAX_WORD_LEN];
  logic [BYTE_W-1:0] a_data_r;
  logic [BYTE_W-1:0] b_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_bank][wr_idx] <= wr_data;
    end
  end

  // read ports, data registered
  always_ff @(posedge clk) begin
    if (a_en) begin
      a_data_r <= mem_r[a_bank][a_idx];
    end
    if (b_en) begin
      b_data_r <= mem_r[b_bank][b_idx];
    end
  end

  assign a_data = a_data_r;
  assign b_data = b_data_r;

endmodule

// ----- rtl/fce_front.sv -----
// ----------------------------------------------------------------------------
// fce_front
// Takes input items, compares each byte with the previous word, stores it,
// and queues a job for the back at every end of word.
// ----------------------------------------------------------------------------
module fce_front #(
  parameter int  MAX_WORD_LEN = fce_pkg::MAX_WORD_LEN_DEF,
  localparam int IDX_W        = $clog2(MAX_WORD_LEN)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [fce_pkg::BYTE_W-1:0] in_char_byte,
  input  logic                       in_has_byte,
  input  logic                       in_end_of_word,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_front_coding_enable,
  // store: compare read of the previous word
  output logic                       rd_en,
  output logic                       rd_bank,
  output logic [IDX_W-1:0]           rd_idx,
  input  logic [fce_pkg::BYTE_W-1:0] rd_data,
  // store: write of the current word
  output logic                       wr_en,
  output logic                       wr_bank,
  output logic [IDX_W-1:0]           wr_idx,
  output logic [fce_pkg::BYTE_W-1:0] wr_data,
  // job queue
  output logic                       job_push,
  output fce_pkg::job_t              job,
  input  logic                       q_full,
  input  fce_pkg::done_t             done
);
  import fce_pkg::*;

  localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_WORD_LEN);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_CMP  = 2'b10
  } fstate_t;

  fstate_t           state_r, state_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              has_r;
  logic              eow_r;
  logic              bank_r, bank_nxt;
  logic [LEN_W-1:0]  prev_len_r, prev_len_nxt;
  logic [LEN_W-1:0]  cur_len_r, cur_len_nxt;
  logic [LEN_W-1:0]  prefix_r, prefix_nxt;
  logic              match_r, match_nxt;
  logic              ovf_r, ovf_nxt;
  logic [1:0]        busy_r, busy_nxt;
  logic              fc_en_r;

  logic              accept;
  logic              room;
  logic              in_cmp;
  logic [LEN_W-1:0]  len_upd;
  logic [LEN_W-1:0]  prefix_upd;
  logic              match_upd;
  logic              ovf_upd;
  logic [LEN_W-1:0]  pre_sel;

  // input handshake: one item in flight, write bank free, job queue not full
  assign in_full   = (state_r != F_IDLE) || busy_r[bank_r] || q_full;
  assign accept    = in_push && !in_full;
  assign cfg_ready = 1'b1;
  assign room      = cur_len_r < MAX_L;
  assign in_cmp    = (state_r == F_CMP);

  // fetch the previous word's byte at the same position
  assign rd_en   = accept && room;
  assign rd_bank = !bank_r;
  assign rd_idx  = cur_len_r[IDX_W-1:0];

  // store the byte into the current bank
  assign wr_en   = in_cmp && has_r && room;
  assign wr_bank = bank_r;
  assign wr_idx  = cur_len_r[IDX_W-1:0];
  assign wr_data = byte_r;

  // byte compare and length update
  always_comb begin
    len_upd    = cur_len_r;
    prefix_upd = prefix_r;
    match_upd  = match_r;
    ovf_upd    = ovf_r;
    if (in_cmp && has_r) begin
      if (room) begin
        if (match_r && (cur_len_r < prev_len_r) && (rd_data == byte_r)) begin
          prefix_upd = prefix_r + LEN_W'(1);
        end else begin
          match_upd = 1'b0;
        end
        len_upd = cur_len_r + LEN_W'(1);
      end else begin
        ovf_upd = 1'b1;
      end
    end
  end

  // word job at the end mark
  assign pre_sel   = fc_en_r ? prefix_upd : '0;
  assign job_push  = in_cmp && eow_r;
  assign job.bank  = bank_r;
  assign job.pre   = pre_sel;
  assign job.suf   = len_upd - pre_sel;
  assign job.len   = len_upd;
  assign job.trunc = ovf_upd;

  // next state
  always_comb begin
    state_nxt    = state_r;
    bank_nxt     = bank_r;
    prev_len_nxt = prev_len_r;
    cur_len_nxt  = len_upd;
    prefix_nxt   = prefix_upd;
    match_nxt    = match_upd;
    ovf_nxt      = ovf_upd;
    busy_nxt     = busy_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_CMP;
        end
      end
      F_CMP: begin
        state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
    if (job_push) begin
      bank_nxt     = !bank_r;
      prev_len_nxt = len_upd;
      cur_len_nxt  = '0;
      prefix_nxt   = '0;
      match_nxt    = 1'b1;
      ovf_nxt      = 1'b0;
    end
    if (done.valid) begin
      busy_nxt[done.bank] = 1'b0;
    end
    if (job_push) begin
      busy_nxt[bank_r] = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      bank_r     <= 1'b0;
      prev_len_r <= '0;
      cur_len_r  <= '0;
      prefix_r   <= '0;
      match_r    <= 1'b1;
      ovf_r      <= 1'b0;
      busy_r     <= '0;
      fc_en_r    <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      bank_r     <= bank_nxt;
      prev_len_r <= prev_len_nxt;
      cur_len_r  <= cur_len_nxt;
      prefix_r   <= prefix_nxt;
      match_r    <= match_nxt;
      ovf_r      <= ovf_nxt;
      busy_r     <= busy_nxt;
      if (cfg_valid) begin
        fc_en_r <= cfg_front_coding_enable;
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_char_byte;
      has_r  <= in_has_byte;
      eow_r  <= in_end_of_word;
    end
  end

endmodule

// ----- rtl/fce_queue.sv -----
// ----------------------------------------------------------------------------
// fce_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module fce_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fce_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output fce_pkg::job_t head_job,
  output logic          not_empty
);
  import fce_pkg::*;

  job_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_job  = q_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/fce_back.sv -----
// ----------------------------------------------------------------------------
// fce_back
// Emits each queued word: a header, then the suffix bytes read back from
// the store, into a one-entry output register.
// ----------------------------------------------------------------------------
module fce_back #(
  parameter int  MAX_WORD_LEN = fce_pkg::MAX_WORD_LEN_DEF,
  localparam int IDX_W        = $clog2(MAX_WORD_LEN)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // job queue
  input  fce_pkg::job_t              q_job,
  input  logic                       q_not_empty,
  output logic                       q_pop,
  output fce_pkg::done_t             done,
  // store read
  output logic                       rd_en,
  output logic                       rd_bank,
  output logic [IDX_W-1:0]           rd_idx,
  input  logic [fce_pkg::BYTE_W-1:0] rd_data,
  // result register
  output fce_pkg::result_t           res,
  output logic                       res_valid,
  input  logic                       res_pop
);
  import fce_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_HDR  = 4'b0010,
    B_ADDR = 4'b0100,
    B_DATA = 4'b1000
  } bstate_t;

  bstate_t          state_r, state_nxt;
  job_t             job_r, job_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  result_t          res_r, res_nxt;
  logic             valid_r, valid_nxt;
  logic             slot_free;
  logic             last_byte;

  assign slot_free = !valid_r || res_pop;
  assign last_byte = ((idx_r + LEN_W'(1)) == job_r.len);
  assign q_pop     = (state_r == B_IDLE) && q_not_empty;

  assign rd_en   = (state_r == B_ADDR);
  assign rd_bank = job_r.bank;
  assign rd_idx  = idx_r[IDX_W-1:0];

  assign res       = res_r;
  assign res_valid = valid_r;

  // emit sequencer
  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    idx_nxt    = idx_r;
    res_nxt    = res_r;
    valid_nxt  = valid_r && !res_pop;
    done.valid = 1'b0;
    done.bank  = job_r.bank;
    unique case (state_r)
      B_IDLE: begin
        if (q_not_empty) begin
          job_nxt   = q_job;
          state_nxt = B_HDR;
        end
      end
      B_HDR: begin
        if (slot_free) begin
          res_nxt.kind  = KIND_HEADER;
          res_nxt.pre   = job_r.pre;
          res_nxt.suf   = job_r.suf;
          res_nxt.data  = '0;
          res_nxt.trunc = job_r.trunc;
          res_nxt.last  = (job_r.suf == '0);
          valid_nxt     = 1'b1;
          idx_nxt       = job_r.pre;
          if (job_r.suf == '0) begin
            done.valid = 1'b1;
            state_nxt  = B_IDLE;
          end else begin
            state_nxt = B_ADDR;
          end
        end
      end
      B_ADDR: begin
        state_nxt = B_DATA;
      end
      B_DATA: begin
        if (slot_free) begin
          res_nxt.kind  = KIND_DATA;
          res_nxt.pre   = '0;
          res_nxt.suf   = '0;
          res_nxt.data  = rd_data;
          res_nxt.trunc = 1'b0;
          res_nxt.last  = last_byte;
          valid_nxt     = 1'b1;
          idx_nxt       = idx_r + LEN_W'(1);
          if (last_byte) begin
            done.valid = 1'b1;
            state_nxt  = B_IDLE;
          end else begin
            state_nxt = B_ADDR;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

endmodule

// ----- rtl/front_coding_encoder.sv -----
// ----------------------------------------------------------------------------
// front_coding_encoder
// Front coding of a sorted lexicon: per word, a header with shared prefix
// and suffix lengths, then the suffix bytes.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------
//   input    | in_push / in_full  | in_char_byte, in_has_byte,
//            |                    | in_end_of_word
//   result   | out_pop/out_empty  | out_item_kind, out_shared_prefix_len,
//            |                    | out_tail_len, out_data_byte,
//            |                    | out_word_truncated, out_last_of_word
//   config   | cfg_valid/cfg_ready| cfg_front_coding_enable
//
// Each input item passes through the front as a store read, then a compare and
// write. The back picks up a word, emits its header, then for each suffix byte
// does a store read, then loads the result register.
// A third word waits at the input while the first is still being emitted
// from the same store bank.
// Reset is synchronous; no clearing pass, the store needs none.
// The result register frees as it is popped, so the back stalls on its own.
// ----------------------------------------------------------------------------
module front_coding_encoder #(
  parameter int MAX_WORD_LEN = fce_pkg::MAX_WORD_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [fce_pkg::BYTE_W-1:0] in_char_byte,
  input  logic                       in_has_byte,
  input  logic                       in_end_of_word,
  // result channel
  input  logic                       out_pop,
  output logic                       out_empty,
  output logic                       out_item_kind,
  output logic [fce_pkg::LEN_W-1:0]  out_shared_prefix_len,
  output logic [fce_pkg::LEN_W-1:0]  out_tail_len,
  output logic [fce_pkg::BYTE_W-1:0] out_data_byte,
  output logic                       out_word_truncated,
  output logic                       out_last_of_word,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_front_coding_enable
);
  import fce_pkg::*;

  localparam int IDX_W = $clog2(MAX_WORD_LEN);

  logic              wr_en;
  logic              wr_bank;
  logic [IDX_W-1:0]  wr_idx;
  logic [BYTE_W-1:0] wr_data;
  logic              a_en;
  logic              a_bank;
  logic [IDX_W-1:0]  a_idx;
  logic [BYTE_W-1:0] a_data;
  logic              b_en;
  logic              b_bank;
  logic [IDX_W-1:0]  b_idx;
  logic [BYTE_W-1:0] b_data;
  logic              job_push;
  job_t              push_job;
  job_t              head_job;
  logic              q_full;
  logic              q_pop;
  logic              q_not_empty;
  done_t             done;
  result_t           res;
  logic              res_valid;

  // front: classify and store
  fce_front #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_push                 (in_push),
    .in_full                 (in_full),
    .in_char_byte            (in_char_byte),
    .in_has_byte             (in_has_byte),
    .in_end_of_word          (in_end_of_word),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_front_coding_enable (cfg_front_coding_enable),
    .rd_en                   (a_en),
    .rd_bank                 (a_bank),
    .rd_idx                  (a_idx),
    .rd_data                 (a_data),
    .wr_en                   (wr_en),
    .wr_bank                 (wr_bank),
    .wr_idx                  (wr_idx),
    .wr_data                 (wr_data),
    .job_push                (job_push),
    .job                     (push_job),
    .q_full                  (q_full),
    .done                    (done)
  );

  // word job queue
  fce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .head_job  (head_job),
    .not_empty (q_not_empty)
  );

  // two-bank word store
  fce_store #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_bank (wr_bank),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .a_en    (a_en),
    .a_bank  (a_bank),
    .a_idx   (a_idx),
    .a_data  (a_data),
    .b_en    (b_en),
    .b_bank  (b_bank),
    .b_idx   (b_idx),
    .b_data  (b_data)
  );

  // back: emit header and suffix
  fce_back #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_job       (head_job),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .done        (done),
    .rd_en       (b_en),
    .rd_bank     (b_bank),
    .rd_idx      (b_idx),
    .rd_data     (b_data),
    .res         (res),
    .res_valid   (res_valid),
    .res_pop     (out_pop)
  );

  // result ports
  assign out_empty             = !res_valid;
  assign out_item_kind         = res.kind;
  assign out_shared_prefix_len = res.pre;
  assign out_tail_len          = res.suf;
  assign out_data_byte         = res.data;
  assign out_word_truncated    = res.trunc;
  assign out_last_of_word      = res.last;

`ifndef SYNTHESIS
  // a transfer in keeps the front busy for its compare cycle
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("input taken during compare cycle");

  // the job queue is never pushed while full
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && q_full))
    else $error("word job lost at full queue");

  // the front never writes the bank the back is reading out
  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && b_en) |-> (wr_bank != b_bank))
    else $error("store write into bank under readout");

  // header lengths stay within the word limit
  a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_item_kind == KIND_HEADER)) |->
      ((int'(out_shared_prefix_len) + int'(out_tail_len)) <= MAX_WORD_LEN))
    else $error("header lengths exceed word limit");
`endif

endmodule
